// ===== src/lctp_pkg.sv =====
// Package for the Lehmer code to permutation decoder.
// Field widths, register reset value and size limits; no dependencies.
package lctp_pkg;

  localparam int unsigned DigitW       = 6;
  localparam int unsigned ElemW        = 6;
  localparam int unsigned LenW         = 7;
  // element field and used mask hold at most this many elements
  localparam int unsigned ElemCap      = 64;
  localparam int unsigned MaxNDefault  = 64;
  localparam logic [LenW-1:0] PermLenReset = 7'd64;

  typedef logic [DigitW-1:0] digit_t;
  typedef logic [ElemW-1:0]  elem_t;
  typedef logic [LenW-1:0]   len_t;

endpackage

// ===== src/lehmer_code_to_permutation.sv =====
// Lehmer code (inversion vector) to permutation decoder, top level.
// Scans the used mask one element per cycle under a small sequencer.
// Depends on lctp_pkg.
//
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_ready_o   digit_i
//   out       output     out_valid_o / out_ready_i element_o, is_last_o
//   cfg       input      cfg_we_i                  cfg_wdata_i (perm_length)
//
// A digit is accepted, then the used mask is scanned one element per cycle up to the
// picked free element, and that element is loaded into the output register once the
// register is free. The last digit of a vector scans a second time for the remaining
// element.
// in_ready_o is high only while the sequencer is idle; a result waiting in the
// output register does not hold off the next digit, only the next load.
// Reset clears the mask and position; perm_length resets to 64, clamped to MAX_N.
// A write to perm_length also drops any partly decoded vector.
module lehmer_code_to_permutation #(
  parameter int unsigned MAX_N = lctp_pkg::MaxNDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lctp_pkg::digit_t digit_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output lctp_pkg::elem_t  element_o,
  output logic             is_last_o,
  input  logic             cfg_we_i,
  input  lctp_pkg::len_t   cfg_wdata_i
);
  import lctp_pkg::*;

  localparam int unsigned NMax = (MAX_N < ElemCap) ? MAX_N : ElemCap;
  localparam int unsigned IdxW = (NMax > 1) ? $clog2(NMax) : 1;
  localparam int unsigned CntW = $clog2(NMax + 1);

  typedef enum logic [1:0] {StIdle, StScan, StEmit} state_e;

  function automatic logic [CntW-1:0] eff_len(input len_t v);
    logic [CntW-1:0] n;
    if (v < len_t'(2)) n = CntW'(2);
    else if (v > len_t'(NMax)) n = CntW'(NMax);
    else n = CntW'(v);
    return n;
  endfunction

  state_e            state_q, state_d;
  logic [CntW-1:0]   n_q, n_d;
  logic [NMax-1:0]   used_q, used_d;
  logic [IdxW-1:0]   pos_q, pos_d;
  logic [IdxW-1:0]   scan_q, scan_d;
  logic [IdxW-1:0]   rank_q, rank_d;
  logic              second_q, second_d;
  logic [IdxW-1:0]   hit_q, hit_d;
  logic              out_valid_q, out_valid_d;
  elem_t             out_elem_q, out_elem_d;
  logic              out_last_q, out_last_d;

  logic [IdxW-1:0]   n_m1;
  logic              in_xfer, slot_free, is_free, found;
  logic [IdxW-1:0]   pos_start;
  logic [7:0]        free_cnt, rank_wide;

  assign n_m1      = IdxW'(n_q - CntW'(1));
  assign in_xfer   = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;
  assign is_free   = !used_q[scan_q];
  assign found     = (is_free && (rank_q == '0)) || (scan_q == n_m1);

  // clamp the digit to the number of free elements minus one
  always_comb begin
    pos_start = (pos_q >= n_m1) ? '0 : pos_q;
    free_cnt  = 8'(n_q) - 8'(pos_start);
    rank_wide = 8'(digit_i);
    if (rank_wide >= free_cnt) rank_wide = free_cnt - 8'd1;
  end

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    used_d      = used_q;
    pos_d       = pos_q;
    scan_d      = scan_q;
    rank_d      = rank_q;
    second_d    = second_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_elem_d  = out_elem_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          if (pos_q >= n_m1) used_d = '0;
          pos_d    = pos_start;
          scan_d   = '0;
          rank_d   = IdxW'(rank_wide);
          second_d = 1'b0;
          state_d  = StScan;
        end
      end
      StScan: begin
        if (found) begin
          hit_d          = scan_q;
          used_d[scan_q] = 1'b1;
          if (!second_q) pos_d = pos_q + IdxW'(1);
          state_d = StEmit;
        end else begin
          if (is_free) rank_d = rank_q - IdxW'(1);
          scan_d = scan_q + IdxW'(1);
        end
      end
      StEmit: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_elem_d  = ElemW'(hit_q);
          out_last_d  = second_q;
          if (second_q) begin
            used_d  = '0;
            pos_d   = '0;
            state_d = StIdle;
          end else if (pos_q == n_m1) begin
            // one element left: find it with a rank-zero scan
            second_d = 1'b1;
            scan_d   = '0;
            rank_d   = '0;
            state_d  = StScan;
          end else begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase

    if (cfg_we_i) begin
      n_d    = eff_len(cfg_wdata_i);
      used_d = '0;
      pos_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      n_q         <= eff_len(PermLenReset);
      used_q      <= '0;
      pos_q       <= '0;
      second_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      used_q      <= used_d;
      pos_q       <= pos_d;
      second_q    <= second_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q     <= scan_d;
    rank_q     <= rank_d;
    hit_q      <= hit_d;
    out_elem_q <= out_elem_d;
    out_last_q <= out_last_d;
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign element_o   = out_elem_q;
  assign is_last_o   = out_last_q;

  // position never reaches the vector length
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < IdxW'(n_q) || n_q == CntW'(NMax))
    else $error("position out of range");

  // loading the last entry clears the vector state
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit && slot_free && second_q) |=> (used_q == '0 && pos_q == '0))
    else $error("vector state not cleared after last entry");

  // a digit transfer starts a scan, so the block is busy next cycle
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("ready after digit transfer");

endmodule
